// ===== src/dtfp_pkg.sv =====
// Shared widths, step counts, register indexes and the arctangent table
// for the fisheye pixel lookup pipeline. No dependencies.
package dtfp_pkg;

   localparam int COMP_W    = 16;               // direction component width
   localparam int FRAC_SH   = 32 - COMP_W;      // scale to a 32-bit component
   localparam int DIM_W     = 13;               // image size register width
   localparam int IDX_W     = 12;               // pixel index width
   localparam int MAX_DIM   = 4096;
   localparam int MAG_W     = COMP_W;           // magnitude of one component
   localparam int SQ_W      = 2 * MAG_W;        // sum of two squares
   localparam int ROOT_W    = (SQ_W + 2 * FRAC_SH) / 2;
   localparam int SQ_STEPS  = ROOT_W;
   localparam int REM_W     = ROOT_W + 4;
   localparam int CD_STEPS  = 17;
   localparam int CD_W      = 36;
   localparam int ANG_W     = 20;
   localparam int THETA_W   = 17;
   localparam int RAD_W     = 12;
   localparam int PR_W      = THETA_W + RAD_W;
   localparam int NUMM_W    = PR_W + MAG_W;
   localparam int NUM_W     = NUMM_W + FRAC_SH;
   localparam int DEN_W     = THETA_W + ROOT_W;
   localparam int DIV_STEPS = IDX_W;
   localparam int OFF_W     = IDX_W + 2;
   localparam int PIPE_DEPTH = 2 + SQ_STEPS + CD_STEPS + 2 + DIV_STEPS + 1;

   localparam logic [THETA_W-1:0] HALF_PI_Q16 = 17'd102944;
   localparam logic [DIM_W-1:0]   DIM_RESET   = 13'd1024;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_COLS = 1'd1;

   // Per-request data that rides along the pipeline.
   typedef struct packed {
      logic               below;
      logic               neg_x;
      logic               neg_y;
      logic               rho_nz;
      logic [MAG_W-1:0]   mag_x;
      logic [MAG_W-1:0]   mag_y;
      logic [COMP_W-1:0]  dir_z;
   } side_type;

   // atan(2^-i) in Q16 radians, rounded to nearest.
   function automatic logic [THETA_W-1:0] atan_q16(input int unsigned step);
      logic [THETA_W-1:0] v;
      case (step)
         0:  v = 17'd51472;
         1:  v = 17'd30385;
         2:  v = 17'd16055;
         3:  v = 17'd8150;
         4:  v = 17'd4091;
         5:  v = 17'd2047;
         6:  v = 17'd1024;
         7:  v = 17'd512;
         8:  v = 17'd256;
         9:  v = 17'd128;
         10: v = 17'd64;
         11: v = 17'd32;
         12: v = 17'd16;
         13: v = 17'd8;
         14: v = 17'd4;
         15: v = 17'd2;
         16: v = 17'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/dtfp_if.sv =====
// Request and response channel interfaces for the fisheye pixel lookup.
// Depends on dtfp_pkg.
interface dtfp_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [dtfp_pkg::COMP_W-1:0] dir_x;
   logic signed [dtfp_pkg::COMP_W-1:0] dir_y;
   logic signed [dtfp_pkg::COMP_W-1:0] dir_z;

   modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface dtfp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        below_horizon;
   logic [dtfp_pkg::IDX_W-1:0]  pixel_row;
   logic [dtfp_pkg::IDX_W-1:0]  pixel_col;

   modport source (output valid, output below_horizon, output pixel_row,
                   output pixel_col, input ready);
   modport sink   (input valid, input below_horizon, input pixel_row,
                   input pixel_col, output ready);
endinterface

// ===== src/dtfp_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per stage, most significant
// first. Depends on dtfp_pkg.
module dtfp_div_pipe (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [dtfp_pkg::NUM_W-1:0]    dividend,
   input  logic [dtfp_pkg::DEN_W-1:0]    divisor,
   output logic [dtfp_pkg::IDX_W-1:0]    quotient
);

   logic [dtfp_pkg::NUM_W-1:0] rem_ff  [dtfp_pkg::DIV_STEPS];
   logic [dtfp_pkg::NUM_W-1:0] rem_in  [dtfp_pkg::DIV_STEPS];
   logic [dtfp_pkg::NUM_W-1:0] rem_src [dtfp_pkg::DIV_STEPS];
   logic [dtfp_pkg::NUM_W-1:0] den_sh  [dtfp_pkg::DIV_STEPS];
   logic [dtfp_pkg::DEN_W-1:0] den_ff  [dtfp_pkg::DIV_STEPS];
   logic [dtfp_pkg::DEN_W-1:0] den_in  [dtfp_pkg::DIV_STEPS];
   logic [dtfp_pkg::IDX_W-1:0] quot_ff [dtfp_pkg::DIV_STEPS];
   logic [dtfp_pkg::IDX_W-1:0] quot_in [dtfp_pkg::DIV_STEPS];
   logic [dtfp_pkg::IDX_W-1:0] quot_src[dtfp_pkg::DIV_STEPS];

   always_comb begin
      for (int k = 0; k < dtfp_pkg::DIV_STEPS; k++) begin
         if (k == 0) begin
            rem_src[k]  = dividend;
            den_in[k]   = divisor;
            quot_src[k] = '0;
         end else begin
            rem_src[k]  = rem_ff[k-1];
            den_in[k]   = den_ff[k-1];
            quot_src[k] = quot_ff[k-1];
         end
         den_sh[k] = dtfp_pkg::NUM_W'(den_in[k]) << (dtfp_pkg::DIV_STEPS - 1 - k);
         if (rem_src[k] >= den_sh[k]) begin
            rem_in[k]  = rem_src[k] - den_sh[k];
            quot_in[k] = quot_src[k]
                         | (dtfp_pkg::IDX_W'(1) << (dtfp_pkg::DIV_STEPS - 1 - k));
         end else begin
            rem_in[k]  = rem_src[k];
            quot_in[k] = quot_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < dtfp_pkg::DIV_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= den_in[k];
            quot_ff[k] <= quot_in[k];
         end
      end
   end

   assign quotient = quot_ff[dtfp_pkg::DIV_STEPS-1];

endmodule

// ===== src/direction_to_fisheye_pixel_unit.sv =====
// Fisheye sky-image pixel lookup for a ray direction.
// Stages from request to response: 2 input stages, 32 square-root stages,
// 17 CORDIC stages, 2 multiply stages, 12 divide stages and an output stage.
// Throughput: one request per cycle; a stalled response freezes every stage.
// Reset (synchronous) clears all valid bits and sets both image sizes to 1024.
// Depends on dtfp_pkg, dtfp_if and dtfp_div_pipe.
module direction_to_fisheye_pixel_unit (
   input  logic                              clock,
   input  logic                              reset,
   dtfp_req_if.sink                          req_chan,
   dtfp_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [dtfp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dtfp_pkg::DIM_W-1:0]        csr_wr_data
);

   // Configuration
   logic [dtfp_pkg::DIM_W-1:0] rows_ff, cols_ff;
   logic [dtfp_pkg::DIM_W-1:0] rows_sat, cols_sat, crow, ccol, rows_max, cols_max;
   logic [dtfp_pkg::RAD_W-1:0] rad;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= dtfp_pkg::DIM_RESET;
         cols_ff <= dtfp_pkg::DIM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            dtfp_pkg::REG_IMAGE_ROWS: rows_ff <= csr_wr_data;
            dtfp_pkg::REG_IMAGE_COLS: cols_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rows_ff == '0)
         rows_sat = dtfp_pkg::DIM_W'(1);
      else if (rows_ff > dtfp_pkg::DIM_W'(dtfp_pkg::MAX_DIM))
         rows_sat = dtfp_pkg::DIM_W'(dtfp_pkg::MAX_DIM);
      else
         rows_sat = rows_ff;
      if (cols_ff == '0)
         cols_sat = dtfp_pkg::DIM_W'(1);
      else if (cols_ff > dtfp_pkg::DIM_W'(dtfp_pkg::MAX_DIM))
         cols_sat = dtfp_pkg::DIM_W'(dtfp_pkg::MAX_DIM);
      else
         cols_sat = cols_ff;
      crow     = rows_sat >> 1;
      ccol     = cols_sat >> 1;
      rows_max = rows_sat - dtfp_pkg::DIM_W'(1);
      cols_max = cols_sat - dtfp_pkg::DIM_W'(1);
      rad      = (crow < ccol) ? crow[dtfp_pkg::RAD_W-1:0] : ccol[dtfp_pkg::RAD_W-1:0];
   end

   // Flow control: the whole pipeline moves unless the output is held.
   logic [dtfp_pkg::PIPE_DEPTH-1:0] vld_ff;
   logic adv, req_acc;

   assign adv            = !vld_ff[dtfp_pkg::PIPE_DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign req_acc        = req_chan.valid && adv;

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (adv)
         vld_ff <= {vld_ff[dtfp_pkg::PIPE_DEPTH-2:0], req_acc};
   end

   // Input stage: magnitudes, squares
   dtfp_pkg::side_type     p0_side_in, p0_side_ff, p1_side_ff;
   logic [dtfp_pkg::SQ_W-1:0] sqx_ff, sqy_ff, p1_rad_ff;

   always_comb begin
      p0_side_in.below  = req_chan.dir_z[dtfp_pkg::COMP_W-1];
      p0_side_in.neg_x  = req_chan.dir_x[dtfp_pkg::COMP_W-1];
      p0_side_in.neg_y  = req_chan.dir_y[dtfp_pkg::COMP_W-1];
      p0_side_in.rho_nz = 1'b0;
      p0_side_in.mag_x  = req_chan.dir_x[dtfp_pkg::COMP_W-1]
                          ? (~req_chan.dir_x + dtfp_pkg::MAG_W'(1)) : req_chan.dir_x;
      p0_side_in.mag_y  = req_chan.dir_y[dtfp_pkg::COMP_W-1]
                          ? (~req_chan.dir_y + dtfp_pkg::MAG_W'(1)) : req_chan.dir_y;
      p0_side_in.dir_z  = req_chan.dir_z;
   end

   // Square root: two radicand bits per stage
   logic [dtfp_pkg::REM_W-1:0]    sq_rem_ff [dtfp_pkg::SQ_STEPS];
   logic [dtfp_pkg::REM_W-1:0]    sq_rem_in [dtfp_pkg::SQ_STEPS];
   logic [dtfp_pkg::REM_W-1:0]    sq_rem_src[dtfp_pkg::SQ_STEPS];
   logic [dtfp_pkg::REM_W-1:0]    sq_shift  [dtfp_pkg::SQ_STEPS];
   logic [dtfp_pkg::REM_W-1:0]    sq_trial  [dtfp_pkg::SQ_STEPS];
   logic [dtfp_pkg::ROOT_W-1:0]   sq_root_ff [dtfp_pkg::SQ_STEPS];
   logic [dtfp_pkg::ROOT_W-1:0]   sq_root_in [dtfp_pkg::SQ_STEPS];
   logic [dtfp_pkg::ROOT_W-1:0]   sq_root_src[dtfp_pkg::SQ_STEPS];
   logic [dtfp_pkg::SQ_W-1:0]     sq_rad_ff [dtfp_pkg::SQ_STEPS];
   logic [dtfp_pkg::SQ_W-1:0]     sq_rad_in [dtfp_pkg::SQ_STEPS];
   logic [2*dtfp_pkg::ROOT_W-1:0] sq_s64    [dtfp_pkg::SQ_STEPS];
   dtfp_pkg::side_type            sq_side_ff[dtfp_pkg::SQ_STEPS];
   dtfp_pkg::side_type            sq_side_in[dtfp_pkg::SQ_STEPS];

   always_comb begin
      for (int k = 0; k < dtfp_pkg::SQ_STEPS; k++) begin
         if (k == 0) begin
            sq_rem_src[k]  = '0;
            sq_root_src[k] = '0;
            sq_rad_in[k]   = p1_rad_ff;
            sq_side_in[k]  = p1_side_ff;
         end else begin
            sq_rem_src[k]  = sq_rem_ff[k-1];
            sq_root_src[k] = sq_root_ff[k-1];
            sq_rad_in[k]   = sq_rad_ff[k-1];
            sq_side_in[k]  = sq_side_ff[k-1];
         end
         sq_s64[k]   = {sq_rad_in[k], {(2*dtfp_pkg::ROOT_W - dtfp_pkg::SQ_W){1'b0}}};
         sq_shift[k] = {sq_rem_src[k][dtfp_pkg::REM_W-3:0],
                        sq_s64[k][2*(dtfp_pkg::SQ_STEPS-1-k) +: 2]};
         sq_trial[k] = dtfp_pkg::REM_W'({sq_root_src[k], 2'b01});
         if (sq_shift[k] >= sq_trial[k]) begin
            sq_rem_in[k]  = sq_shift[k] - sq_trial[k];
            sq_root_in[k] = {sq_root_src[k][dtfp_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_in[k]  = sq_shift[k];
            sq_root_in[k] = {sq_root_src[k][dtfp_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   // CORDIC vectoring of (z, rho)
   logic signed [dtfp_pkg::CD_W-1:0]  cd_x_ff [dtfp_pkg::CD_STEPS];
   logic signed [dtfp_pkg::CD_W-1:0]  cd_x_in [dtfp_pkg::CD_STEPS];
   logic signed [dtfp_pkg::CD_W-1:0]  cd_x_src[dtfp_pkg::CD_STEPS];
   logic signed [dtfp_pkg::CD_W-1:0]  cd_y_ff [dtfp_pkg::CD_STEPS];
   logic signed [dtfp_pkg::CD_W-1:0]  cd_y_in [dtfp_pkg::CD_STEPS];
   logic signed [dtfp_pkg::CD_W-1:0]  cd_y_src[dtfp_pkg::CD_STEPS];
   logic signed [dtfp_pkg::ANG_W-1:0] cd_a_ff [dtfp_pkg::CD_STEPS];
   logic signed [dtfp_pkg::ANG_W-1:0] cd_a_in [dtfp_pkg::CD_STEPS];
   logic signed [dtfp_pkg::ANG_W-1:0] cd_a_src[dtfp_pkg::CD_STEPS];
   logic signed [dtfp_pkg::ANG_W-1:0] cd_atan [dtfp_pkg::CD_STEPS];
   logic [dtfp_pkg::ROOT_W-1:0]       cd_rho_ff[dtfp_pkg::CD_STEPS];
   logic [dtfp_pkg::ROOT_W-1:0]       cd_rho_in[dtfp_pkg::CD_STEPS];
   dtfp_pkg::side_type                cd_side_ff[dtfp_pkg::CD_STEPS];
   dtfp_pkg::side_type                cd_side_in[dtfp_pkg::CD_STEPS];
   logic [dtfp_pkg::COMP_W-1:0]       sq_z;

   assign sq_z = sq_side_ff[dtfp_pkg::SQ_STEPS-1].dir_z;

   always_comb begin
      for (int k = 0; k < dtfp_pkg::CD_STEPS; k++) begin
         if (k == 0) begin
            cd_x_src[k]  = {{(dtfp_pkg::CD_W - dtfp_pkg::COMP_W - dtfp_pkg::FRAC_SH)
                             {sq_z[dtfp_pkg::COMP_W-1]}}, sq_z, {dtfp_pkg::FRAC_SH{1'b0}}};
            cd_y_src[k]  = {{(dtfp_pkg::CD_W - dtfp_pkg::ROOT_W){1'b0}},
                            sq_root_ff[dtfp_pkg::SQ_STEPS-1]};
            cd_a_src[k]  = '0;
            cd_rho_in[k] = sq_root_ff[dtfp_pkg::SQ_STEPS-1];
            cd_side_in[k] = sq_side_ff[dtfp_pkg::SQ_STEPS-1];
            cd_side_in[k].rho_nz = (sq_root_ff[dtfp_pkg::SQ_STEPS-1] != '0);
         end else begin
            cd_x_src[k]   = cd_x_ff[k-1];
            cd_y_src[k]   = cd_y_ff[k-1];
            cd_a_src[k]   = cd_a_ff[k-1];
            cd_rho_in[k]  = cd_rho_ff[k-1];
            cd_side_in[k] = cd_side_ff[k-1];
         end
         cd_atan[k] = dtfp_pkg::ANG_W'(dtfp_pkg::atan_q16(k));
         if (!cd_y_src[k][dtfp_pkg::CD_W-1] && (cd_y_src[k] != '0)) begin
            cd_x_in[k] = cd_x_src[k] + (cd_y_src[k] >>> k);
            cd_y_in[k] = cd_y_src[k] - (cd_x_src[k] >>> k);
            cd_a_in[k] = cd_a_src[k] + cd_atan[k];
         end else begin
            cd_x_in[k] = cd_x_src[k] - (cd_y_src[k] >>> k);
            cd_y_in[k] = cd_y_src[k] + (cd_x_src[k] >>> k);
            cd_a_in[k] = cd_a_src[k] - cd_atan[k];
         end
      end
   end

   // Multiply stages
   logic signed [dtfp_pkg::ANG_W-1:0] cd_a_last;
   logic [dtfp_pkg::THETA_W-1:0] theta;
   logic [dtfp_pkg::PR_W-1:0]    m1_prod_ff;
   logic [dtfp_pkg::DEN_W-1:0]   m1_den_ff, m2_den_ff;
   logic [dtfp_pkg::NUMM_W-1:0]  m2_numx_ff, m2_numy_ff;
   dtfp_pkg::side_type           m1_side_ff, m2_side_ff;

   assign cd_a_last = cd_a_ff[dtfp_pkg::CD_STEPS-1];

   always_comb begin
      if (cd_a_last[dtfp_pkg::ANG_W-1])
         theta = '0;
      else if (cd_a_last > dtfp_pkg::ANG_W'(dtfp_pkg::HALF_PI_Q16))
         theta = dtfp_pkg::HALF_PI_Q16;
      else
         theta = cd_a_last[dtfp_pkg::THETA_W-1:0];
   end

   // Divide stages
   logic [dtfp_pkg::IDX_W-1:0] quot_x, quot_y;
   dtfp_pkg::side_type         dv_side_ff[dtfp_pkg::DIV_STEPS];

   dtfp_div_pipe u_div_x (
      .clock    (clock),
      .advance  (adv),
      .dividend ({m2_numx_ff, {dtfp_pkg::FRAC_SH{1'b0}}}),
      .divisor  (m2_den_ff),
      .quotient (quot_x)
   );

   dtfp_div_pipe u_div_y (
      .clock    (clock),
      .advance  (adv),
      .dividend ({m2_numy_ff, {dtfp_pkg::FRAC_SH{1'b0}}}),
      .divisor  (m2_den_ff),
      .quotient (quot_y)
   );

   // Output stage: offsets around the center, clamp to the image
   dtfp_pkg::side_type dv_last;
   logic signed [dtfp_pkg::OFF_W-1:0] col_off, row_off, col_sum, row_sum;
   logic [dtfp_pkg::IDX_W-1:0] row_in, col_in, row_ff, col_ff;
   logic below_ff;

   assign dv_last = dv_side_ff[dtfp_pkg::DIV_STEPS-1];

   always_comb begin
      if (!dv_last.rho_nz)
         col_off = '0;
      else if (dv_last.neg_x)
         col_off = dtfp_pkg::OFF_W'(0) - dtfp_pkg::OFF_W'(quot_x);
      else
         col_off = dtfp_pkg::OFF_W'(quot_x);
      if (!dv_last.rho_nz)
         row_off = '0;
      else if (dv_last.neg_y)
         row_off = dtfp_pkg::OFF_W'(quot_y);
      else
         row_off = dtfp_pkg::OFF_W'(0) - dtfp_pkg::OFF_W'(quot_y);
      col_sum = signed'(dtfp_pkg::OFF_W'(ccol)) + col_off;
      row_sum = signed'(dtfp_pkg::OFF_W'(crow)) + row_off;
      if (dv_last.below || col_sum[dtfp_pkg::OFF_W-1])
         col_in = '0;
      else if (col_sum > signed'(dtfp_pkg::OFF_W'(cols_max)))
         col_in = cols_max[dtfp_pkg::IDX_W-1:0];
      else
         col_in = col_sum[dtfp_pkg::IDX_W-1:0];
      if (dv_last.below || row_sum[dtfp_pkg::OFF_W-1])
         row_in = '0;
      else if (row_sum > signed'(dtfp_pkg::OFF_W'(rows_max)))
         row_in = rows_max[dtfp_pkg::IDX_W-1:0];
      else
         row_in = row_sum[dtfp_pkg::IDX_W-1:0];
   end

   // Payload registers: advance together with the valid bits
   always_ff @(posedge clock) begin
      if (adv) begin
         p0_side_ff <= p0_side_in;
         sqx_ff     <= dtfp_pkg::SQ_W'(p0_side_in.mag_x) * dtfp_pkg::SQ_W'(p0_side_in.mag_x);
         sqy_ff     <= dtfp_pkg::SQ_W'(p0_side_in.mag_y) * dtfp_pkg::SQ_W'(p0_side_in.mag_y);
         p1_side_ff <= p0_side_ff;
         p1_rad_ff  <= sqx_ff + sqy_ff;
         for (int k = 0; k < dtfp_pkg::SQ_STEPS; k++) begin
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            sq_rad_ff[k]  <= sq_rad_in[k];
            sq_side_ff[k] <= sq_side_in[k];
         end
         for (int k = 0; k < dtfp_pkg::CD_STEPS; k++) begin
            cd_x_ff[k]    <= cd_x_in[k];
            cd_y_ff[k]    <= cd_y_in[k];
            cd_a_ff[k]    <= cd_a_in[k];
            cd_rho_ff[k]  <= cd_rho_in[k];
            cd_side_ff[k] <= cd_side_in[k];
         end
         m1_prod_ff <= dtfp_pkg::PR_W'(theta) * dtfp_pkg::PR_W'(rad);
         m1_den_ff  <= dtfp_pkg::DEN_W'(dtfp_pkg::HALF_PI_Q16)
                       * dtfp_pkg::DEN_W'(cd_rho_ff[dtfp_pkg::CD_STEPS-1]);
         m1_side_ff <= cd_side_ff[dtfp_pkg::CD_STEPS-1];
         m2_numx_ff <= dtfp_pkg::NUMM_W'(m1_prod_ff) * dtfp_pkg::NUMM_W'(m1_side_ff.mag_x);
         m2_numy_ff <= dtfp_pkg::NUMM_W'(m1_prod_ff) * dtfp_pkg::NUMM_W'(m1_side_ff.mag_y);
         m2_den_ff  <= m1_den_ff;
         m2_side_ff <= m1_side_ff;
         dv_side_ff[0] <= m2_side_ff;
         for (int k = 1; k < dtfp_pkg::DIV_STEPS; k++)
            dv_side_ff[k] <= dv_side_ff[k-1];
         below_ff <= dv_last.below;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   assign rsp_chan.valid         = vld_ff[dtfp_pkg::PIPE_DEPTH-1];
   assign rsp_chan.below_horizon = below_ff;
   assign rsp_chan.pixel_row     = row_ff;
   assign rsp_chan.pixel_col     = col_ff;

endmodule

// ===== tb/sv/tb_dtfp_checker.sv =====
// Response checker for the fisheye pixel lookup: predicts each pixel from
// accepted requests and compares responses. Depends on dtfp_pkg, dtfp_if.
module tb_dtfp_checker (
   input  logic                 clock,
   input  logic                 reset,
   dtfp_req_if                  req_mon,
   dtfp_rsp_if                  rsp_mon,
   input  logic                 csr_wr_en,
   input  logic [dtfp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dtfp_pkg::DIM_W-1:0]     csr_wr_data,
   output int                   fail_count,
   output int                   pending_count
);

   typedef struct packed {
      logic                       below;
      logic [dtfp_pkg::IDX_W-1:0] row;
      logic [dtfp_pkg::IDX_W-1:0] col;
   } pixel_type;

   localparam longint ATAN_TAB [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
      512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

   logic [dtfp_pkg::DIM_W-1:0] rows_reg, cols_reg;
   pixel_type pixel_queue[$];

   function automatic longint floor_shift(longint v, int sh);
      if (v < 0) return -1 - ((-1 - v) >>> sh);
      return v >>> sh;
   endfunction

   function automatic longint int_sqrt(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint zenith_angle(longint zq, longint rq);
      longint cx, cy, ang, nx;
      cx = zq;
      cy = rq;
      ang = 0;
      for (int i = 0; i < 17; i++) begin
         if (cy > 0) begin
            nx = cx + floor_shift(cy, i);
            cy = cy - floor_shift(cx, i);
            ang += ATAN_TAB[i];
         end else begin
            nx = cx - floor_shift(cy, i);
            cy = cy + floor_shift(cx, i);
            ang -= ATAN_TAB[i];
         end
         cx = nx;
      end
      if (ang < 0) ang = 0;
      if (ang > 102944) ang = 102944;
      return ang;
   endfunction

   function automatic longint sat_size(logic [dtfp_pkg::DIM_W-1:0] v);
      if (v < 1) return 1;
      if (v > dtfp_pkg::MAX_DIM) return dtfp_pkg::MAX_DIM;
      return v;
   endfunction

   function automatic longint clamp_index(longint v, longint n);
      if (v < 0) return 0;
      if (v > n - 1) return n - 1;
      return v;
   endfunction

   function automatic pixel_type predict_pixel(logic signed [dtfp_pkg::COMP_W-1:0] dx,
         logic signed [dtfp_pkg::COMP_W-1:0] dy, logic signed [dtfp_pkg::COMP_W-1:0] dz);
      longint x, y, z, nrows, ncols, crow, ccol, rad, roff, coff, rq, th;
      longint unsigned ax, ay, den, q;
      pixel_type p;
      x = longint'(dx) * (64'sd1 <<< dtfp_pkg::FRAC_SH);
      y = longint'(dy) * (64'sd1 <<< dtfp_pkg::FRAC_SH);
      z = longint'(dz) * (64'sd1 <<< dtfp_pkg::FRAC_SH);
      nrows = sat_size(rows_reg);
      ncols = sat_size(cols_reg);
      crow = nrows / 2;
      ccol = ncols / 2;
      rad = crow < ccol ? crow : ccol;
      roff = 0;
      coff = 0;
      p = '0;
      if (z < 0) begin
         p.below = 1'b1;
         return p;
      end
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      rq = int_sqrt(ax * ax + ay * ay);
      if (rq != 0) begin
         th = zenith_angle(z, rq);
         den = 64'd102944 * rq;
         q = (th * rad * ax) / den;
         coff = x < 0 ? -longint'(q) : longint'(q);
         q = (th * rad * ay) / den;
         roff = y < 0 ? longint'(q) : -longint'(q);
      end
      p.row = dtfp_pkg::IDX_W'(clamp_index(crow + roff, nrows));
      p.col = dtfp_pkg::IDX_W'(clamp_index(ccol + coff, ncols));
      return p;
   endfunction

   assign pending_count = pixel_queue.size();

   always @(posedge clock) begin
      pixel_type want, got;
      if (reset) begin
         rows_reg <= dtfp_pkg::DIM_RESET;
         cols_reg <= dtfp_pkg::DIM_RESET;
         pixel_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == dtfp_pkg::REG_IMAGE_ROWS) rows_reg <= csr_wr_data;
            else if (csr_index == dtfp_pkg::REG_IMAGE_COLS) cols_reg <= csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready)
            pixel_queue.push_back(predict_pixel(req_mon.dir_x, req_mon.dir_y,
                                                req_mon.dir_z));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.below_horizon, rsp_mon.pixel_row, rsp_mon.pixel_col};
            if (pixel_queue.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_queue.pop_front();
               if (want != got) begin
                  $display("%0t: pixel mismatch, expected %p, actual %p",
                           $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/sv/tb_direction_to_fisheye_pixel_unit.sv =====
// Stimulus and verdict for the fisheye pixel lookup unit.
// Depends on dtfp_pkg, dtfp_if, the unit and tb_dtfp_checker.
module tb_direction_to_fisheye_pixel_unit;

   logic clock, reset;
   logic csr_wr_en;
   logic [dtfp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dtfp_pkg::DIM_W-1:0] csr_wr_data;
   int fail_count, pending_count;
   logic drain_mode;
   int hold_cycles;

   dtfp_req_if req_chan ();
   dtfp_rsp_if rsp_chan ();

   direction_to_fisheye_pixel_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data));

   tb_dtfp_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count));

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("direction_to_fisheye_pixel_unit verification failed");
      $finish;
   end

   // Receiver: random stall bursts, one long hold-off, none when draining.
   initial begin
      rsp_chan.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_chan.ready <= 0;
            hold_cycles = hold_cycles - 1;
            @(negedge clock);
         end else if (!drain_mode && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Valid stays high after the accepting edge; the next request or an idle
   // stretch takes it over at the same falling edge.
   task automatic send_request(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               bit gaps);
      if (gaps && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.dir_x <= x;
      req_chan.dir_y <= y;
      req_chan.dir_z <= z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      req_chan.valid <= 0;
      while (pending_count != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (80) @(negedge clock);
   endtask

   task automatic write_sizes(logic [dtfp_pkg::DIM_W-1:0] r,
                              logic [dtfp_pkg::DIM_W-1:0] c);
      csr_wr_en <= 1;
      csr_index <= dtfp_pkg::REG_IMAGE_ROWS;
      csr_wr_data <= r;
      @(negedge clock);
      csr_index <= dtfp_pkg::REG_IMAGE_COLS;
      csr_wr_data <= c;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(signed'($urandom_range(0, 40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] edge_vals [6];
      logic [dtfp_pkg::DIM_W-1:0] size_set [8];
      edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h4000};
      size_set = '{13'd1, 13'd2, 13'd4096, 13'd8191, 13'd0, 13'd640, 13'd3, 13'd1999};
      reset = 1;
      drain_mode = 0;
      hold_cycles = 0;
      req_chan.valid = 0;
      req_chan.dir_x = 0;
      req_chan.dir_y = 0;
      req_chan.dir_z = 0;
      csr_wr_en = 0;
      csr_index = dtfp_pkg::REG_IMAGE_ROWS;
      csr_wr_data = 0;
      repeat (6) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // Directed: zero and vertical vectors, horizon, below horizon, extremes.
      send_request(16'h0000, 16'h0000, 16'h0000, 0);
      send_request(16'h0000, 16'h0000, 16'h7fff, 0);
      send_request(16'h7fff, 16'h0000, 16'h0000, 0);
      send_request(16'h8000, 16'h0000, 16'h0000, 0);
      send_request(16'h0000, 16'h7fff, 16'h0000, 0);
      send_request(16'h0000, 16'h8000, 16'h0000, 0);
      send_request(16'h8000, 16'h8000, 16'h0000, 0);
      send_request(16'h7fff, 16'h7fff, 16'h7fff, 0);
      send_request(16'h0001, 16'hffff, 16'h0001, 0);
      send_request(16'h1234, 16'h4321, 16'hffff, 0);
      send_request(16'h8000, 16'h8000, 16'h8000, 0);
      for (int i = 0; i < 6; i++)
         send_request(edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6], 0);

      // Long receiver hold-off while requests keep coming.
      hold_cycles = 200;
      for (int i = 0; i < 120; i++) send_request(rand_comp(), rand_comp(), rand_comp(), 0);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         write_sizes(size_set[ph], size_set[(ph + 3) % 8]);
         send_request(16'h7fff, 16'h0000, 16'h0000, 0);
         send_request(16'h0000, 16'h8000, 16'h0000, 0);
         for (int i = 0; i < 95; i++)
            send_request(rand_comp(), rand_comp(), rand_comp(), 1);
         wait_idle();
      end

      write_sizes(dtfp_pkg::DIM_RESET, 13'd777);
      drain_mode = 1;
      for (int i = 0; i < 60; i++) send_request(rand_comp(), rand_comp(), rand_comp(), 0);
      wait_idle();

      if (fail_count == 0 && pending_count == 0)
         $display("direction_to_fisheye_pixel_unit verification clean");
      else
         $display("direction_to_fisheye_pixel_unit verification failed");
      $finish;
   end
endmodule
